// File: sv/ipv4_rhc_pkg.sv
// Shared types and constants for the IPv4 receive header checker.
package ipv4_rhc_pkg;

    localparam int HDR_MIN_BYTES = 20;
    localparam logic [3:0]  IP_VERSION_4 = 4'd4;
    localparam logic [15:0] FRAG_MASK    = 16'h3FFF;
    localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [15:0] SUM_GOOD     = 16'hFFFF;

    localparam logic [31:0] LOCAL_ADDR_RESET  = 32'h0A00_020F;
    localparam logic [31:0] SUBNET_MASK_RESET = 32'hFFFF_FF00;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        VERDICT_DELIVERED   = 3'd0,
        VERDICT_TRUNCATED   = 3'd1,
        VERDICT_BAD_VERSION = 3'd2,
        VERDICT_BAD_CSUM    = 3'd3,
        VERDICT_FRAGMENT    = 3'd4,
        VERDICT_NOT_FOR_US  = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        CLASS_ICMP  = 2'd0,
        CLASS_UDP   = 2'd1,
        CLASS_TCP   = 2'd2,
        CLASS_OTHER = 2'd3
    } proto_class_t;

    typedef enum logic {
        REG_LOCAL_ADDR  = 1'b0,
        REG_SUBNET_MASK = 1'b1
    } cfg_reg_t;

    // Header summary of one packet, handed from the parser to the checker.
    typedef struct packed {
        logic [15:0] pkt_len;
        logic [7:0]  ver_ihl;
        logic [15:0] csum;
        logic [15:0] total_len;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
    } hdr_rec_t;

endpackage

// File: sv/ipv4_rhc_parser.sv
// Byte-stream front end: counts bytes, folds the header checksum, captures fields.
module ipv4_rhc_parser
    import ipv4_rhc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic [7:0] s_tdata,   // [7:0] pkt_byte
    input  logic     s_tlast,     // last_byte
    input  logic     q_full,
    output logic     q_push,
    output hdr_rec_t q_rec
);

    localparam logic [15:0] OFS_TLEN_HI = 16'd2;
    localparam logic [15:0] OFS_TLEN_LO = 16'd3;
    localparam logic [15:0] OFS_FRAG_HI = 16'd6;
    localparam logic [15:0] OFS_FRAG_LO = 16'd7;
    localparam logic [15:0] OFS_PROTO   = 16'd9;
    localparam logic [15:0] OFS_SRC0    = 16'd12;
    localparam logic [15:0] OFS_SRC1    = 16'd13;
    localparam logic [15:0] OFS_SRC2    = 16'd14;
    localparam logic [15:0] OFS_SRC3    = 16'd15;
    localparam logic [15:0] OFS_DST0    = 16'd16;
    localparam logic [15:0] OFS_DST1    = 16'd17;
    localparam logic [15:0] OFS_DST2    = 16'd18;
    localparam logic [15:0] OFS_DST3    = 16'd19;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    logic [15:0] count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  first_reg, first_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] frag_reg, frag_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [5:0]  ihl_bytes;
    logic [16:0] sum_wide;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && s_tlast;

    always_comb
    begin
        first_next = (count_reg == 16'd0) ? s_tdata : first_reg;
        ihl_bytes  = {first_next[3:0], 2'b00};
        hold_next  = hold_reg;
        sum_next   = sum_reg;
        sum_wide   = 17'd0;
        total_next = total_reg;
        frag_next  = frag_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;

        // fold header words with end-around carry
        if (count_reg < {10'd0, ihl_bytes})
        begin
            if (!count_reg[0])
            begin
                hold_next = s_tdata;
            end
            else
            begin
                sum_wide = {1'b0, sum_reg} + {1'b0, hold_reg, s_tdata};
                sum_next = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
            end
        end

        case (count_reg)
            OFS_TLEN_HI: total_next = {s_tdata, total_reg[7:0]};
            OFS_TLEN_LO: total_next = {total_reg[15:8], s_tdata};
            OFS_FRAG_HI: frag_next  = {s_tdata, frag_reg[7:0]};
            OFS_FRAG_LO: frag_next  = {frag_reg[15:8], s_tdata};
            OFS_PROTO:   proto_next = s_tdata;
            OFS_SRC0, OFS_SRC1, OFS_SRC2, OFS_SRC3:
                src_next = {src_reg[23:0], s_tdata};
            OFS_DST0, OFS_DST1, OFS_DST2, OFS_DST3:
                dst_next = {dst_reg[23:0], s_tdata};
            default: ;
        endcase

        // saturate the byte count
        count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : (count_reg + 16'd1);

        q_rec.pkt_len   = count_next;
        q_rec.ver_ihl   = first_next;
        q_rec.csum      = sum_next;
        q_rec.total_len = total_next;
        q_rec.frag      = frag_next;
        q_rec.proto     = proto_next;
        q_rec.src       = src_next;
        q_rec.dst       = dst_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            first_reg <= '0;
            total_reg <= '0;
            frag_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                // start the next packet from a clean state
                count_reg <= '0;
                sum_reg   <= '0;
                hold_reg  <= '0;
                first_reg <= '0;
                total_reg <= '0;
                frag_reg  <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                hold_reg  <= hold_next;
                first_reg <= first_next;
                total_reg <= total_next;
                frag_reg  <= frag_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (count_reg == 16'd0) && (sum_reg == 16'd0))
        else $error("parser state not cleared after last byte");

endmodule

// File: sv/ipv4_rhc_fifo.sv
// Short queue of header summaries between the parser and the checker.
module ipv4_rhc_fifo
    import ipv4_rhc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  hdr_rec_t push_rec,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output hdr_rec_t head_rec
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    hdr_rec_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : (wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : (rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue count past depth");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> head_valid)
        else $error("pushed summary not visible");

endmodule

// File: sv/ipv4_rhc_judge.sv
// Back end: holds configuration, forms the verdict and drives the result register.
module ipv4_rhc_judge
    import ipv4_rhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        rec_valid,
    input  hdr_rec_t    rec,
    output logic        rec_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // protocol_num, source_addr, dest_addr, header_bytes,
                                  // payload_bytes, zero pad
    output logic [5:0]  m_tuser   // verdict, proto_class, is_broadcast
);

    logic [31:0]  local_addr_reg;
    logic [31:0]  subnet_mask_reg;
    logic         valid_reg;
    verdict_t     verdict_reg, verdict_next;
    proto_class_t class_reg, class_next;
    logic [7:0]   proto_reg, proto_next;
    logic         bcast_reg, bcast_next;
    logic [31:0]  src_reg, src_next;
    logic [31:0]  dst_reg, dst_next;
    logic [5:0]   hdr_reg, hdr_next;
    logic [15:0]  pay_reg, pay_next;
    logic [31:0]  dir_bcast;
    logic [15:0]  ihl16;
    logic         is_b;
    verdict_t     verdict;
    proto_class_t pclass;

    assign cfg_ready = 1'b1;
    assign rec_pop   = rec_valid && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg  <= LOCAL_ADDR_RESET;
            subnet_mask_reg <= SUBNET_MASK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LOCAL_ADDR:  local_addr_reg  <= cfg_data;
                REG_SUBNET_MASK: subnet_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ihl16     = {10'd0, rec.ver_ihl[3:0], 2'b00};
        dir_bcast = (local_addr_reg & subnet_mask_reg) | ~subnet_mask_reg;
        is_b      = (rec.dst == ADDR_ALL_ONES) || (rec.dst == dir_bcast);

        // checks in priority order
        if (rec.pkt_len < 16'(HDR_MIN_BYTES))
            verdict = VERDICT_TRUNCATED;
        else if (rec.ver_ihl[7:4] != IP_VERSION_4)
            verdict = VERDICT_BAD_VERSION;
        else if (ihl16 < 16'(HDR_MIN_BYTES) || ihl16 > rec.pkt_len)
            verdict = VERDICT_TRUNCATED;
        else if (rec.csum != SUM_GOOD)
            verdict = VERDICT_BAD_CSUM;
        else if (rec.total_len < ihl16 || rec.total_len > rec.pkt_len)
            verdict = VERDICT_TRUNCATED;
        else if ((rec.frag & FRAG_MASK) != 16'd0)
            verdict = VERDICT_FRAGMENT;
        else if (rec.dst != local_addr_reg && !is_b)
            verdict = VERDICT_NOT_FOR_US;
        else
            verdict = VERDICT_DELIVERED;

        case (rec.proto)
            PROTO_ICMP: pclass = CLASS_ICMP;
            PROTO_UDP:  pclass = CLASS_UDP;
            PROTO_TCP:  pclass = CLASS_TCP;
            default:    pclass = CLASS_OTHER;
        endcase

        verdict_next = verdict;
        if (verdict == VERDICT_DELIVERED)
        begin
            class_next = pclass;
            proto_next = rec.proto;
            bcast_next = is_b;
            src_next   = rec.src;
            dst_next   = rec.dst;
            hdr_next   = ihl16[5:0];
            pay_next   = rec.total_len - ihl16;
        end
        else
        begin
            // rejected packets carry nothing but the verdict
            class_next = CLASS_ICMP;
            proto_next = '0;
            bcast_next = 1'b0;
            src_next   = '0;
            dst_next   = '0;
            hdr_next   = '0;
            pay_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rec_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            verdict_reg <= verdict_next;
            class_reg   <= class_next;
            proto_reg   <= proto_next;
            bcast_reg   <= bcast_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            hdr_reg     <= hdr_next;
            pay_reg     <= pay_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, pay_reg, hdr_reg, dst_reg, src_reg, proto_reg};
    assign m_tuser  = {bcast_reg, class_reg, verdict_reg};

    a_reject_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && verdict_reg != VERDICT_DELIVERED) |->
            (src_reg == 32'd0 && dst_reg == 32'd0 && pay_reg == 16'd0 && !bcast_reg))
        else $error("rejected result carries header fields");

    a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !m_tready) |-> !rec_pop)
        else $error("result overwritten while stalled");

endmodule

// File: sv/ipv4_receive_header_checker.sv
// Top level of the IPv4 receive header checker.
//
// Input stream (s_*): one packet byte per transaction, s_tlast on the final
// byte. Bytes are taken one per cycle; s_tready drops only while the summary
// queue between the parser and the checker is full.
// Output stream (m_*): one result transaction per packet, issued for the
// byte that carries s_tlast. Its summary enters the queue when that byte is
// accepted; the result register, which drives m_tvalid, loads from the queue head
// once it is free. Throughput: one byte per cycle unless the queue is full, and
// one result per cycle while m_tready is high, even for back-to-back one-byte
// packets; the parser folds one header byte per cycle and the checker forms one
// verdict per cycle from a registered summary.
// Configuration (cfg_*): index 0 writes the local unicast address, index 1
// the subnet mask; cfg_ready is always high. Write only while no packet is
// in flight.
// Reset: parser state and queue are emptied, no result is pending, the
// address registers return to 10.0.2.15 and 255.255.255.0.
// Stall: while m_tready is low the result holds; the queue absorbs up to
// QUEUE_DEPTH further packet summaries before s_tready drops.
module ipv4_receive_header_checker
    import ipv4_rhc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pkt_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [7:0] protocol_num, [39:8] source_addr,
                                   // [71:40] dest_addr, [77:72] header_bytes,
                                   // [93:78] payload_bytes, [95:94] zero
    output logic [5:0]  m_tuser,   // [2:0] verdict, [4:3] proto_class, [5] is_broadcast
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    hdr_rec_t push_rec;
    hdr_rec_t head_rec;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;

    ipv4_rhc_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    ipv4_rhc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (push_rec),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_rec   (head_rec)
    );

    ipv4_rhc_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_valid (q_valid),
        .rec       (head_rec),
        .rec_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
